// ===== sv/ltr_pkg.sv =====
// Shared types and constants for the tiled line rasterizer.
`default_nettype none

package ltr_pkg;

  localparam int ADDR_W        = 16;  // byte address width
  localparam int TILE_SHIFT    = 5;   // 32 bytes per tile
  localparam int TILE_PX_SHIFT = 3;   // 8 pixels per tile side
  localparam int STRIDE_W      = ADDR_W - TILE_SHIFT;
  localparam int TW_W          = 6;
  localparam int PEN_W         = 4;
  localparam int COORD_IN_W    = 8;

  localparam logic [TW_W-1:0] TW_RESET = 6'd1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              high_nibble;
    logic [PEN_W-1:0]  color;
    logic              last;
  } res_t;

  // Width of a decoded command for a given coordinate width:
  // op, pen, x1, y1, x2, y2, dx, dy, step_left, step_up, err, drawing
  function automatic int cmd_bits(input int cb);
    return 1 + PEN_W + 6 * cb + 2 + (cb + 2) + 1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ltr_fifo.sv =====
// Two-entry register queue used between the stages and at the output.
`default_nettype none

module ltr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/ltr_front.sv =====
// Front end: takes input items and decodes loads into ready-to-run commands.
`default_nettype none

module ltr_front #(
  parameter int COORD_BITS = 8
) (
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   opcode,
  input  logic [ltr_pkg::COORD_IN_W-1:0]         start_x,
  input  logic [ltr_pkg::COORD_IN_W-1:0]         start_y,
  input  logic [ltr_pkg::COORD_IN_W-1:0]         stop_x,
  input  logic [ltr_pkg::COORD_IN_W-1:0]         stop_y,
  input  logic [ltr_pkg::PEN_W-1:0]              pen_in,
  output logic                                   cmd_push,
  output logic [ltr_pkg::cmd_bits(COORD_BITS)-1:0] cmd,
  input  logic                                   cmd_full
);

  import ltr_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int ERR_W = COORD_BITS + 2;

  typedef struct packed {
    opcode_t                  op;
    logic [PEN_W-1:0]         pen;
    logic [CB-1:0]            x1;
    logic [CB-1:0]            y1;
    logic [CB-1:0]            x2;
    logic [CB-1:0]            y2;
    logic [CB-1:0]            dx;
    logic [CB-1:0]            dy;
    logic                     step_left;
    logic                     step_up;
    logic signed [ERR_W-1:0]  err;
    logic                     drawing;
  } cmd_t;

  cmd_t          c;
  logic [CB-1:0] x1, y1, x2, y2;

  assign x1 = CB'(start_x);
  assign y1 = CB'(start_y);
  assign x2 = CB'(stop_x);
  assign y2 = CB'(stop_y);

  always_comb begin
    c.op        = opcode_t'(opcode);
    c.pen       = pen_in;
    c.x1        = x1;
    c.y1        = y1;
    c.x2        = x2;
    c.y2        = y2;
    c.dx        = (x2 >= x1) ? x2 - x1 : x1 - x2;
    c.dy        = (y2 >= y1) ? y2 - y1 : y1 - y2;
    c.step_left = (x1 >= x2);
    c.step_up   = (y1 >= y2);
    c.err       = $signed({2'b00, c.dx}) - $signed({2'b00, c.dy});
    // start == stop: nothing to draw
    c.drawing   = !((x1 == x2) && (y1 == y2));
  end

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;
  assign cmd      = c;

endmodule

`default_nettype wire

// ===== sv/ltr_back.sv =====
// Back end: line state, one Bresenham step and one tiled address per cycle while not stalled.
`default_nettype none

module ltr_back #(
  parameter int COORD_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [ltr_pkg::TW_W-1:0]                 cfg_data,
  input  logic [ltr_pkg::cmd_bits(COORD_BITS)-1:0] cmd,
  input  logic                                     cmd_empty,
  output logic                                     cmd_pop,
  input  logic                                     out_full,
  output logic                                     res_push,
  output ltr_pkg::res_t                            res
);

  import ltr_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int ERR_W = COORD_BITS + 2;

  typedef struct packed {
    opcode_t                  op;
    logic [PEN_W-1:0]         pen;
    logic [CB-1:0]            x1;
    logic [CB-1:0]            y1;
    logic [CB-1:0]            x2;
    logic [CB-1:0]            y2;
    logic [CB-1:0]            dx;
    logic [CB-1:0]            dy;
    logic                     step_left;
    logic                     step_up;
    logic signed [ERR_W-1:0]  err;
    logic                     drawing;
  } cmd_t;

  cmd_t c;
  assign c = cmd;

  logic [TW_W-1:0]         tiles_wide;
  logic [CB-1:0]           cur_x, cur_y, goal_x, goal_y, delta_x, delta_y;
  logic signed [ERR_W-1:0] error_term;
  logic                    step_left, step_up, drawing;
  logic [PEN_W-1:0]        pen_color;

  logic                    go;
  logic                    do_step;
  logic signed [ERR_W:0]   e2, dx_s, dy_s, err_wide;
  logic                    move_x, move_y;
  logic [CB-1:0]           cur_x_next, cur_y_next;
  logic                    hit;
  logic [STRIDE_W-1:0]     twm1, row_mul;
  logic [ADDR_W-1:0]       addr;

  assign go       = !cmd_empty && !out_full;
  assign cmd_pop  = go;
  assign do_step  = go && (c.op == OP_STEP) && drawing;
  assign res_push = do_step;

  // Bresenham step, both tests on the old error
  always_comb begin
    e2       = {error_term, 1'b0};
    dx_s     = $signed({3'b000, delta_x});
    dy_s     = $signed({3'b000, delta_y});
    move_x   = (e2 > -dy_s);
    move_y   = (e2 < dx_s);
    err_wide = {error_term[ERR_W-1], error_term};
    if (move_x) begin
      err_wide = err_wide - dy_s;
    end
    if (move_y) begin
      err_wide = err_wide + dx_s;
    end
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (move_x) begin
      cur_x_next = step_left ? cur_x - CB'(1) : cur_x + CB'(1);
    end
    if (move_y) begin
      cur_y_next = step_up ? cur_y - CB'(1) : cur_y + CB'(1);
    end
    hit = (cur_x_next == goal_x) && (cur_y_next == goal_y);
  end

  // Tile-row stride: (tiles_wide-1) wraps, only its low bits survive the *32
  always_comb begin
    twm1    = STRIDE_W'(tiles_wide) - STRIDE_W'(1);
    row_mul = STRIDE_W'(STRIDE_W'(cur_y >> TILE_PX_SHIFT) * twm1);
    addr    = ADDR_W'({cur_x >> TILE_PX_SHIFT, {TILE_SHIFT{1'b0}}})
            + ADDR_W'(cur_x[TILE_PX_SHIFT-1:1])
            + ADDR_W'({cur_y, 2'b00})
            + {row_mul, {TILE_SHIFT{1'b0}}};
  end

  always_comb begin
    res.addr        = addr;
    res.high_nibble = cur_x[0];
    res.color       = pen_color;
    res.last        = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_wide <= TW_RESET;
      cur_x      <= '0;
      cur_y      <= '0;
      goal_x     <= '0;
      goal_y     <= '0;
      delta_x    <= '0;
      delta_y    <= '0;
      error_term <= '0;
      step_left  <= 1'b0;
      step_up    <= 1'b0;
      pen_color  <= '0;
      drawing    <= 1'b0;
    end else begin
      if (cfg_write) begin
        tiles_wide <= cfg_data;
      end
      if (go && (c.op == OP_LOAD)) begin
        cur_x      <= c.x1;
        cur_y      <= c.y1;
        goal_x     <= c.x2;
        goal_y     <= c.y2;
        delta_x    <= c.dx;
        delta_y    <= c.dy;
        error_term <= c.err;
        step_left  <= c.step_left;
        step_up    <= c.step_up;
        pen_color  <= c.pen;
        drawing    <= c.drawing;
      end else if (do_step) begin
        cur_x      <= cur_x_next;
        cur_y      <= cur_y_next;
        error_term <= err_wide[ERR_W-1:0];
        drawing    <= !hit;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/line_rasterizer_tiled_unit.sv =====
// Top level of the tiled line rasterizer.
// Draws Bresenham lines as nibble writes into a 4-bit-per-pixel bitmap of
// 8x8 tiles (32 bytes each). A load item (opcode 0) sets the endpoints and
// the color and gives no result; each step item (opcode 1) gives one pixel
// write while a line is active, with last_pixel set on the final one. The
// stop point is never drawn. Sustained rate is one item per clock while the
// result side is popped; the back end does one Bresenham update and one
// address sum per cycle, which sets that figure. A step item passes the
// command queue, then the back end writes its pixel into the result queue,
// from which it is popped. tiles_wide may only be changed while no line
// work is pending.
`default_nettype none

module line_rasterizer_tiled_unit #(
  parameter int COORD_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ltr_pkg::TW_W-1:0]       cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic                           opcode,
  input  logic [ltr_pkg::COORD_IN_W-1:0] start_x,
  input  logic [ltr_pkg::COORD_IN_W-1:0] start_y,
  input  logic [ltr_pkg::COORD_IN_W-1:0] stop_x,
  input  logic [ltr_pkg::COORD_IN_W-1:0] stop_y,
  input  logic [ltr_pkg::PEN_W-1:0]      pen_in,
  output logic                           empty,
  input  logic                           pop,
  output logic [ltr_pkg::ADDR_W-1:0]     byte_address,
  output logic                           high_nibble,
  output logic [ltr_pkg::PEN_W-1:0]      pixel_color,
  output logic                           last_pixel
);

  import ltr_pkg::*;

  localparam int CMD_W = cmd_bits(COORD_BITS);
  localparam int RES_W = $bits(res_t);

  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0] cmd_in, cmd_out;
  logic             res_push, out_full;
  res_t             res_in, res_out;
  logic [RES_W-1:0] res_out_bits;

  ltr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .push     (push),
    .full     (full),
    .opcode   (opcode),
    .start_x  (start_x),
    .start_y  (start_y),
    .stop_x   (stop_x),
    .stop_y   (stop_y),
    .pen_in   (pen_in),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  ltr_fifo #(.WIDTH(CMD_W)) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  ltr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  ltr_fifo #(.WIDTH(RES_W)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (out_full),
    .pop     (pop),
    .rd_data (res_out_bits),
    .empty   (empty)
  );

  assign res_out      = res_out_bits;
  assign byte_address = res_out.addr;
  assign high_nibble  = res_out.high_nibble;
  assign pixel_color  = res_out.color;
  assign last_pixel   = res_out.last;

endmodule

`default_nettype wire

// ===== sv/ltr_checker.sv =====
// Port-level checks for the tiled line rasterizer, bound to the top level.
`default_nettype none

module ltr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           push,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic [ltr_pkg::ADDR_W-1:0]     byte_address,
  input logic                           high_nibble,
  input logic [ltr_pkg::PEN_W-1:0]      pixel_color,
  input logic                           last_pixel
);

  // Both queues start empty, and an item must pass both queues before a result shows.
  a_reset_latency: assert property (@(posedge clk)
    rst |=> (empty && !full) ##1 (empty && !full))
    else $error("queues not clear after reset");

  // The input side only fills up on an edge that took an item.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    (full && !$past(full)) |-> $past(push))
    else $error("full rose without an accepted item");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(byte_address) && $stable(high_nibble) &&
                          $stable(pixel_color) && $stable(last_pixel)))
    else $error("waiting result changed");

endmodule

bind line_rasterizer_tiled_unit ltr_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .byte_address (byte_address),
  .high_nibble  (high_nibble),
  .pixel_color  (pixel_color),
  .last_pixel   (last_pixel)
);

`default_nettype wire
